// ----- design/tccc_pkg.sv -----
// Shared types, codes and constants for the text console cursor command unit.
// No dependencies; every other design file refers to this package by scope.
package tccc_pkg;

    localparam int DefCellWidth  = 8;
    localparam int DefCellHeight = 16;
    localparam int DefQueueDepth = 4;

    localparam int PosWidth = 12;

    // Request types on the input channel.
    localparam logic [1:0] REQ_CHAR  = 2'd0;
    localparam logic [1:0] REQ_BLINK = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FG_COLOR     = 3'd0;
    localparam logic [2:0] CFG_BG_COLOR     = 3'd1;
    localparam logic [2:0] CFG_CURSOR_COLOR = 3'd2;
    localparam logic [2:0] CFG_SCREEN_W     = 3'd3;
    localparam logic [2:0] CFG_SCREEN_H     = 3'd4;

    localparam logic [31:0]         RST_FG_COLOR     = 32'hFFFF_FFFF;
    localparam logic [31:0]         RST_BG_COLOR     = 32'hFF78_45A8;
    localparam logic [31:0]         RST_CURSOR_COLOR = 32'hFF9B_6FD0;
    localparam logic [PosWidth-1:0] RST_SCREEN_W     = 12'd1024;
    localparam logic [PosWidth-1:0] RST_SCREEN_H     = 12'd768;

    // Character codes with special handling.
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_BS        = 8'h08;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_PRINT_MAX = 8'h7E;

    // Bit positions in a plan's command mask, in emission order.
    localparam int PLAN_ERASE  = 0;
    localparam int PLAN_SCROLL = 1;
    localparam int PLAN_GLYPH  = 2;
    localparam int PLAN_FILL   = 3;
    localparam int PLAN_CLEAR  = 4;
    localparam int PlanCmds    = 5;

    typedef enum logic [2:0] {
        CMD_FILL_CURSOR  = 3'd0,
        CMD_ERASE_CURSOR = 3'd1,
        CMD_GLYPH        = 3'd2,
        CMD_SCROLL       = 3'd3,
        CMD_CLEAR        = 3'd4
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
    } req_t;

    typedef struct packed {
        cmd_kind_t            cmd_kind;
        logic [PosWidth-1:0]  x_pos;
        logic [PosWidth-1:0]  y_pos;
        logic [7:0]           glyph_code;
        logic [31:0]          fore_color;
        logic [31:0]          back_color;
        logic                 last;
    } cmd_t;

    typedef struct packed {
        logic [31:0]          fg_color;
        logic [31:0]          bg_color;
        logic [31:0]          cursor_color;
        logic [PosWidth-1:0]  screen_width;
        logic [PosWidth-1:0]  screen_height;
    } cfg_t;

    // Decoded work for one request: which commands to emit and where.
    typedef struct packed {
        logic [PlanCmds-1:0]  cmds;
        logic [PosWidth-1:0]  erase_x;
        logic [PosWidth-1:0]  erase_y;
        logic [PosWidth-1:0]  glyph_x;
        logic [PosWidth-1:0]  glyph_y;
        logic [7:0]           glyph_code;
        logic [PosWidth-1:0]  fill_x;
        logic [PosWidth-1:0]  fill_y;
    } plan_t;

endpackage

// ----- design/tccc_front.sv -----
// Front end: accepts requests, tracks the cursor and decodes each request into a plan.
// Depends on tccc_pkg.
module tccc_front #(
    parameter int CELL_WIDTH  = tccc_pkg::DefCellWidth,
    parameter int CELL_HEIGHT = tccc_pkg::DefCellHeight
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  tccc_pkg::req_t  req,
    input  tccc_pkg::cfg_t  cfg,
    output logic            plan_valid,
    output tccc_pkg::plan_t plan
);

    localparam int PW = tccc_pkg::PosWidth;
    localparam logic [PW+1:0] CW_EXT = (PW + 2)'(CELL_WIDTH);
    localparam logic [PW+1:0] CH_EXT = (PW + 2)'(CELL_HEIGHT);
    localparam logic [PW-1:0] CW_POS = PW'(CELL_WIDTH);
    localparam logic [PW-1:0] CH_POS = PW'(CELL_HEIGHT);

    logic [PW-1:0] col_reg, col_next;
    logic [PW-1:0] row_reg, row_next;
    logic          shown_reg, shown_next;

    logic [PW+1:0] nl_y;
    logic          nl_scroll;
    logic [PW-1:0] nl_row;
    logic          wrap;
    logic          printable;
    logic [PW-1:0] gx;
    logic [PW-1:0] gy;

    always_comb
    begin
        // New line: the row steps down one cell unless that would reach the bottom,
        // in which case the screen scrolls and the row stays put.
        nl_y      = {2'b00, row_reg} + CH_EXT;
        nl_scroll = (nl_y + CH_EXT) >= {2'b00, cfg.screen_height};
        nl_row    = nl_scroll ? row_reg : row_reg + CH_POS;
        wrap      = ({2'b00, col_reg} + CW_EXT) >= {2'b00, cfg.screen_width};
        printable = (req.char_code >= tccc_pkg::CHAR_SPACE) &&
                    (req.char_code <= tccc_pkg::CHAR_PRINT_MAX);
        gx        = wrap ? '0 : col_reg;
        gy        = wrap ? nl_row : row_reg;

        col_next   = col_reg;
        row_next   = row_reg;
        shown_next = shown_reg;
        plan       = '0;
        plan.erase_x = col_reg;
        plan.erase_y = row_reg;
        plan_valid = 1'b0;

        case (req.req_type)
            tccc_pkg::REQ_CHAR:
            begin
                plan_valid = 1'b1;
                plan.cmds[tccc_pkg::PLAN_ERASE] = shown_reg;
                plan.cmds[tccc_pkg::PLAN_FILL]  = 1'b1;
                shown_next = 1'b1;
                if (req.char_code == tccc_pkg::CHAR_LF)
                begin
                    col_next = '0;
                    row_next = nl_row;
                    plan.cmds[tccc_pkg::PLAN_SCROLL] = nl_scroll;
                end
                else if (req.char_code == tccc_pkg::CHAR_CR)
                begin
                    col_next = '0;
                end
                else if (req.char_code == tccc_pkg::CHAR_BS)
                begin
                    if ({2'b00, col_reg} >= CW_EXT)
                    begin
                        col_next = col_reg - CW_POS;
                        plan.cmds[tccc_pkg::PLAN_GLYPH] = 1'b1;
                        plan.glyph_x    = col_reg - CW_POS;
                        plan.glyph_y    = row_reg;
                        plan.glyph_code = tccc_pkg::CHAR_SPACE;
                    end
                end
                else if (printable)
                begin
                    plan.cmds[tccc_pkg::PLAN_SCROLL] = wrap && nl_scroll;
                    plan.cmds[tccc_pkg::PLAN_GLYPH]  = 1'b1;
                    plan.glyph_x    = gx;
                    plan.glyph_y    = gy;
                    plan.glyph_code = req.char_code;
                    col_next = gx + CW_POS;
                    row_next = gy;
                end
            end
            tccc_pkg::REQ_BLINK:
            begin
                plan_valid = 1'b1;
                plan.cmds[tccc_pkg::PLAN_ERASE] = shown_reg;
                plan.cmds[tccc_pkg::PLAN_FILL]  = !shown_reg;
                shown_next = !shown_reg;
            end
            tccc_pkg::REQ_CLEAR:
            begin
                plan_valid = 1'b1;
                plan.cmds[tccc_pkg::PLAN_CLEAR] = 1'b1;
                shown_next = 1'b0;
                col_next   = '0;
                row_next   = '0;
            end
            default:
            begin
                plan_valid = 1'b0;
            end
        endcase

        plan.fill_x = col_next;
        plan.fill_y = row_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            shown_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            shown_reg <= shown_next;
        end
    end

endmodule

// ----- design/tccc_queue.sv -----
// Small first-in first-out queue of decoded plans between front and back end.
// Depends on tccc_pkg.
module tccc_queue #(
    parameter int DEPTH = tccc_pkg::DefQueueDepth
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  tccc_pkg::plan_t wr_data,
    input  logic            rd_en,
    output tccc_pkg::plan_t rd_data,
    output logic            full,
    output logic            empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

    tccc_pkg::plan_t store_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_wr;
    logic            do_rd;

    assign full    = (count_reg == DepthCnt);
    assign empty   = (count_reg == '0);
    assign rd_data = store_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CntW'(do_wr) - CntW'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/tccc_back.sv -----
// Back end: walks each plan's command mask, one command per cycle unless stalled.
// Depends on tccc_pkg; the result register here faces the output channel.
module tccc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  tccc_pkg::cfg_t  cfg,
    input  logic            q_empty,
    input  tccc_pkg::plan_t q_data,
    output logic            q_pop,
    input  logic            pop,
    output logic            empty,
    output tccc_pkg::cmd_t  cmd
);

    localparam int NC = tccc_pkg::PlanCmds;

    tccc_pkg::plan_t cur_reg, cur_next;
    logic [NC-1:0]   mask_reg, mask_next;
    logic            out_valid_reg, out_valid_next;
    tccc_pkg::cmd_t  out_reg, out_next;

    logic [NC-1:0]   sel;
    logic [NC-1:0]   mask_after;
    logic            can_emit;
    logic            emit;
    logic            load;

    always_comb
    begin
        // Lowest pending bit goes first; the mask order is the emission order.
        sel = mask_reg & (~mask_reg + 1'b1);

        can_emit   = !out_valid_reg || pop;
        emit       = can_emit && (mask_reg != '0);
        mask_after = emit ? (mask_reg & ~sel) : mask_reg;
        load       = (mask_after == '0) && !q_empty;
        q_pop      = load;
        mask_next  = load ? q_data.cmds : mask_after;
        cur_next   = load ? q_data : cur_reg;

        out_next            = out_reg;
        out_next.x_pos      = '0;
        out_next.y_pos      = '0;
        out_next.glyph_code = '0;
        out_next.back_color = '0;
        out_next.last       = (mask_after == '0);
        if (sel[tccc_pkg::PLAN_ERASE])
        begin
            out_next.cmd_kind   = tccc_pkg::CMD_ERASE_CURSOR;
            out_next.x_pos      = cur_reg.erase_x;
            out_next.y_pos      = cur_reg.erase_y;
            out_next.fore_color = cfg.bg_color;
        end
        else if (sel[tccc_pkg::PLAN_SCROLL])
        begin
            out_next.cmd_kind   = tccc_pkg::CMD_SCROLL;
            out_next.fore_color = cfg.bg_color;
            out_next.back_color = cfg.bg_color;
        end
        else if (sel[tccc_pkg::PLAN_GLYPH])
        begin
            out_next.cmd_kind   = tccc_pkg::CMD_GLYPH;
            out_next.x_pos      = cur_reg.glyph_x;
            out_next.y_pos      = cur_reg.glyph_y;
            out_next.glyph_code = cur_reg.glyph_code;
            out_next.fore_color = cfg.fg_color;
            out_next.back_color = cfg.bg_color;
        end
        else if (sel[tccc_pkg::PLAN_FILL])
        begin
            out_next.cmd_kind   = tccc_pkg::CMD_FILL_CURSOR;
            out_next.x_pos      = cur_reg.fill_x;
            out_next.y_pos      = cur_reg.fill_y;
            out_next.fore_color = cfg.cursor_color;
        end
        else
        begin
            out_next.cmd_kind   = tccc_pkg::CMD_CLEAR;
            out_next.fore_color = cfg.bg_color;
            out_next.back_color = cfg.bg_color;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty = !out_valid_reg;
    assign cmd   = out_reg;

endmodule

// ----- design/text_console_cursor_commands_unit.sv -----
// Text console cursor command unit: top level with configuration registers.
// Depends on tccc_pkg, tccc_front, tccc_queue and tccc_back.
//
// Usage: requests (character, cursor blink toggle, clear screen) enter through
// push/full; a transaction happens on a clock edge with push high and full low.
// Draw commands leave through empty/pop in the order erase cursor, scroll,
// glyph, fill cursor, clear; the last command of a request carries last = 1.
// A request decodes into up to four commands in the cycle it is accepted and
// waits in a queue of QUEUE_DEPTH entries (four by default). The first command
// of a request goes through the queue, the plan register and the result
// register to the result ports. The back end issues one command per cycle
// unless the receiver stalls; a request yields one to four commands; requests
// of unused type produce nothing. Requests keep being taken while commands
// wait, until the queue fills; a stalled receiver then raises full.
// Configuration writes are always ready and should happen only while the unit
// is idle. Reset puts the cursor at the top left, not drawn, and loads the
// default colors and a 1024 by 768 screen.
module text_console_cursor_commands_unit #(
    parameter int CELL_WIDTH  = tccc_pkg::DefCellWidth,
    parameter int CELL_HEIGHT = tccc_pkg::DefCellHeight,
    parameter int QUEUE_DEPTH = tccc_pkg::DefQueueDepth
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  tccc_pkg::req_t req,
    output logic           empty,
    input  logic           pop,
    output tccc_pkg::cmd_t cmd,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data
);

    tccc_pkg::cfg_t  cfg_reg;
    tccc_pkg::plan_t plan;
    logic            plan_valid;
    tccc_pkg::plan_t q_data;
    logic            q_empty;
    logic            q_pop;
    logic            accept;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fg_color      <= tccc_pkg::RST_FG_COLOR;
            cfg_reg.bg_color      <= tccc_pkg::RST_BG_COLOR;
            cfg_reg.cursor_color  <= tccc_pkg::RST_CURSOR_COLOR;
            cfg_reg.screen_width  <= tccc_pkg::RST_SCREEN_W;
            cfg_reg.screen_height <= tccc_pkg::RST_SCREEN_H;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tccc_pkg::CFG_FG_COLOR:     cfg_reg.fg_color     <= cfg_data;
                tccc_pkg::CFG_BG_COLOR:     cfg_reg.bg_color     <= cfg_data;
                tccc_pkg::CFG_CURSOR_COLOR: cfg_reg.cursor_color <= cfg_data;
                tccc_pkg::CFG_SCREEN_W:
                    cfg_reg.screen_width  <= cfg_data[tccc_pkg::PosWidth-1:0];
                tccc_pkg::CFG_SCREEN_H:
                    cfg_reg.screen_height <= cfg_data[tccc_pkg::PosWidth-1:0];
                default:
                begin
                end
            endcase
        end
    end

    tccc_front #(
        .CELL_WIDTH  (CELL_WIDTH),
        .CELL_HEIGHT (CELL_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req        (req),
        .cfg        (cfg_reg),
        .plan_valid (plan_valid),
        .plan       (plan)
    );

    tccc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && plan_valid),
        .wr_data (plan),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    tccc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .cmd     (cmd)
    );

endmodule
